// ===== hw/rtl/rbl_pkg.sv =====
package rbl_pkg;

  // Default length of one breathing period, in ticks
  localparam int PHASES_DEF = 120;

  // Channel full scale and breathing peak, out of full scale
  localparam int FULL_SCALE  = 255;
  localparam int BREATH_PEAK = 45;

  // Request codes
  localparam logic [1:0] REQ_SET   = 2'd0;
  localparam logic [1:0] REQ_BREATH = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // floor(x / 255) for any 16-bit x below 65535: (x + (x >> 8) + 1) >> 8
  function automatic logic [8:0] div255_16(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return sum[16:8];
  endfunction

endpackage

// ===== hw/rtl/rgb_breathing_led_generator.sv =====
// Breathing RGB LED value generator. Requests: set color (scaled at once by
// the brightness register, ends breathing), start breathing (latches the base
// color and restarts the phase, no result; a repeat with the same color while
// breathing changes nothing) and timer tick (while breathing, steps the phase
// and gives the base color times a gamma-shaped triangle envelope, peak 45/255).
// One request is worked at a time and in_stall stays high meanwhile. A set
// color passes through the channel multiply-divide lanes and then into the
// output register; a tick first runs the envelope sequencer, then the lanes,
// then loads the output register. Other requests never raise in_stall. The
// result waits in the lanes while the output is stalled.
// The output register lets a new request be taken while the last result waits.
// brightness resets to 15 and is written via wr_en/wr_data; the user must
// write it only while the block is idle, which the block does not enforce.
module rgb_breathing_led_generator
  import rbl_pkg::*;
#(
  parameter int PHASES = PHASES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [7:0] wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  localparam int PW = $clog2(PHASES);
  localparam logic [PW-1:0] PHASE_LAST = PW'(PHASES - 1);

  // Control codes
  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_ENV  = 2'd1;
  localparam logic [1:0] T_LANE = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [7:0]    brightness;
  logic          breathing_on;
  logic [PW-1:0] phase;
  logic [PW-1:0] phase_next;
  logic [23:0]   base_colour;

  logic          accept;
  logic          is_set;
  logic          is_breath;
  logic          is_tick;
  logic          same_colour;
  logic          env_start;
  logic          env_done;
  logic [7:0]    amp;
  logic          lane_start;
  logic [7:0]    lane_scale;
  logic [7:0]    lane_in [3];
  logic [7:0]    lane_out [3];
  logic [2:0]    lane_done;
  logic          slot_free;
  logic          load;

  assign in_stall    = (state != T_IDLE);
  assign accept      = in_valid && !in_stall;
  assign is_set      = (req_type == REQ_SET);
  assign is_breath   = (req_type == REQ_BREATH);
  assign is_tick     = (req_type == REQ_TICK);
  assign same_colour = breathing_on && ({red, green, blue} == base_colour);
  assign phase_next  = (phase == PHASE_LAST) ? '0 : phase + 1'b1;
  assign env_start   = accept && is_tick && breathing_on;

  // Lanes start on a set color request or when the envelope is ready
  assign lane_start = (accept && is_set) || env_done;
  assign lane_scale = env_done ? amp : brightness;
  assign lane_in[0] = env_done ? base_colour[23:16] : red;
  assign lane_in[1] = env_done ? base_colour[15:8]  : green;
  assign lane_in[2] = env_done ? base_colour[7:0]   : blue;

  assign slot_free = !out_valid || !out_stall;
  assign load      = (state == T_LANE) && lane_done[0] && slot_free;

  // Request sequencing
  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE: begin
        if (env_start) begin
          state_next = T_ENV;
        end else if (accept && is_set) begin
          state_next = T_LANE;
        end
      end
      T_ENV:  if (env_done) state_next = T_LANE;
      T_LANE: if (load) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= 8'd15;
    end else if (wr_en) begin
      brightness <= wr_data;
    end
  end

  // Breathing state
  always_ff @(posedge clk) begin
    if (rst) begin
      breathing_on <= 1'b0;
      phase        <= '0;
      base_colour  <= '0;
    end else if (accept) begin
      if (is_set) begin
        breathing_on <= 1'b0;
      end else if (is_breath && !same_colour) begin
        breathing_on <= 1'b1;
        phase        <= '0;
        base_colour  <= {red, green, blue};
      end else if (is_tick && breathing_on) begin
        phase <= phase_next;
      end
    end
  end

  rbl_env #(
    .PHASES(PHASES)
  ) u_env (
    .clk  (clk),
    .rst  (rst),
    .start(env_start),
    .phase(phase_next),
    .amp  (amp),
    .done (env_done)
  );

  // One lane per color channel
  for (genvar i = 0; i < 3; i++) begin : g_lane
    rbl_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .start(lane_start),
      .chan (lane_in[i]),
      .scale(lane_scale),
      .level(lane_out[i]),
      .done (lane_done[i])
    );
  end

  // Merge the lanes into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_red   <= lane_out[0];
      out_green <= lane_out[1];
      out_blue  <= lane_out[2];
    end
  end

  // A breathing start, a tick while not breathing or an unused code leaves the block free next cycle
  a_ignored_free: assert property (@(posedge clk) disable iff (rst)
    accept && !is_set && !(is_tick && breathing_on) |=> !in_stall)
    else $error("ignored request left block busy");

  // Envelope completes only while the controller waits for it
  a_env_done_state: assert property (@(posedge clk) disable iff (rst)
    env_done |-> state == T_ENV)
    else $error("envelope done outside envelope wait");

  // All lanes finish together
  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] == lane_done[1] && lane_done[1] == lane_done[2])
    else $error("lane completion mismatch");

  // Breathing stops only on an accepted set color request
  a_breath_stop: assert property (@(posedge clk) disable iff (rst)
    $fell(breathing_on) |-> $past(accept && is_set))
    else $error("breathing stopped without set color");

endmodule

// ===== hw/rtl/rbl_lane.sv =====
// One color channel: c * k / 255, product register then divide register
module rbl_lane
  import rbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] chan,
  input  logic [7:0] scale,
  output logic [7:0] level,
  output logic       done
);

  logic [15:0] prod;
  logic [8:0]  quot;
  logic        busy;

  assign quot = div255_16(prod);

  // Control: busy for the divide step, done held until the next start
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  // Datapath: product, then divide by full scale
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= chan * scale;
    end
    if (busy) begin
      level <= quot[7:0];
    end
  end

endmodule

// ===== hw/rtl/rbl_env.sv =====
// Breathing envelope: triangle from phase, cubic gamma, scaled to the peak.
// One step per cycle through a small sequencer; amp is valid when done pulses.
module rbl_env
  import rbl_pkg::*;
#(
  parameter int PHASES = PHASES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [$clog2(PHASES)-1:0] phase,
  output logic [7:0]                amp,
  output logic                      done
);

  localparam int PW    = $clog2(PHASES);
  localparam int HALF  = PHASES / 2;
  localparam int NW    = PW + 8;
  localparam int SH    = NW;
  localparam int MW    = SH + 1;
  localparam int RECIP = (2 ** SH) / HALF;

  localparam logic [PW-1:0] HALF_P   = PW'(HALF);
  localparam logic [PW:0]   PHASES_P = (PW + 1)'(PHASES);
  localparam logic [NW-1:0] HALF_N   = NW'(HALF);
  localparam logic [MW-1:0] RECIP_M  = MW'(RECIP);

  // floor(2^23 / 255): quotient estimate for a 24-bit numerator
  localparam logic [15:0] RECIP_255 = 16'd32896;

  // Sequencer codes
  localparam logic [3:0] E_IDLE  = 4'd0;
  localparam logic [3:0] E_RECIP = 4'd1;
  localparam logic [3:0] E_FIX   = 4'd2;
  localparam logic [3:0] E_SQ    = 4'd3;
  localparam logic [3:0] E_CUBE  = 4'd4;
  localparam logic [3:0] E_DIV   = 4'd5;
  localparam logic [3:0] E_FIX2  = 4'd6;
  localparam logic [3:0] E_GAM   = 4'd7;
  localparam logic [3:0] E_AMP   = 4'd8;
  localparam logic [3:0] E_OUT   = 4'd9;

  logic [3:0]       state;
  logic [3:0]       state_next;

  logic [PW-1:0]    op;
  logic [NW-1:0]    num;
  logic [NW-1:0]    quo;
  logic [7:0]       lin;
  logic [15:0]      sq;
  logic [23:0]      cube;
  logic [15:0]      cq;
  logic [15:0]      gq;
  logic [7:0]       gam;
  logic [13:0]      pk;

  logic [NW+MW-1:0] recip_prod;
  logic [2*NW-1:0]  back_prod;
  logic [NW-1:0]    rem;
  logic [NW-1:0]    quo_fix;
  logic [39:0]      cube_prod;
  logic [23:0]      cube_back;
  logic [23:0]      cube_rem;
  logic [8:0]       gam_q;
  logic [8:0]       amp_q;

  // Rising half uses the phase, falling half mirrors it
  assign op = (phase < HALF_P) ? phase : PW'(PHASES_P - {1'b0, phase});

  // Quotient estimate and its one-step correction for phase*255/half
  assign recip_prod = {{MW{1'b0}}, num} * {{NW{1'b0}}, RECIP_M};
  assign back_prod  = {{NW{1'b0}}, quo} * {{NW{1'b0}}, HALF_N};
  assign rem        = num - back_prod[NW-1:0];
  assign quo_fix    = quo + {{(NW-1){1'b0}}, (rem >= HALF_N)};

  // Cube divided by 255 with the same estimate-and-correct scheme
  assign cube_prod = {16'b0, cube} * {24'b0, RECIP_255};
  assign cube_back = {cq, 8'b0} - {8'b0, cq};
  assign cube_rem  = cube - cube_back;

  // Final divides by full scale
  assign gam_q = div255_16(gq);
  assign amp_q = div255_16({2'b0, pk});

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      E_IDLE:  if (start) state_next = E_RECIP;
      E_RECIP: state_next = E_FIX;
      E_FIX:   state_next = E_SQ;
      E_SQ:    state_next = E_CUBE;
      E_CUBE:  state_next = E_DIV;
      E_DIV:   state_next = E_FIX2;
      E_FIX2:  state_next = E_GAM;
      E_GAM:   state_next = E_AMP;
      E_AMP:   state_next = E_OUT;
      E_OUT:   state_next = E_IDLE;
      default: state_next = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == E_OUT);
    end
  end

  // Datapath, one register per step
  always_ff @(posedge clk) begin
    unique case (state)
      E_IDLE:  if (start) num <= {op, 8'b0} - {8'b0, op};
      E_RECIP: quo <= recip_prod[SH+NW-1:SH];
      E_FIX:   lin <= (quo_fix > NW'(FULL_SCALE)) ? 8'(FULL_SCALE) : quo_fix[7:0];
      E_SQ:    sq <= lin * lin;
      E_CUBE:  cube <= sq * lin;
      E_DIV:   cq <= cube_prod[38:23];
      E_FIX2:  gq <= cq + {15'b0, (cube_rem >= 24'(FULL_SCALE))};
      E_GAM:   gam <= gam_q[7:0];
      E_AMP:   pk <= gam * 6'(BREATH_PEAK);
      E_OUT:   amp <= amp_q[7:0];
      default: ;
    endcase
  end

endmodule

// ===== tb/rgb_breathing_led_generator_tb.sv =====
`timescale 1ns / 1ps

module rgb_breathing_led_generator_tb
  import rbl_pkg::*;
();

  localparam int PHASE_COUNT = PHASES_DEF;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int NUM_DIRECTED = 21;
  localparam int NUM_PHASES = 4;
  localparam int ITEMS_PER_PHASE = 195;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic       cfg;
    logic [7:0] cfg_val;
    logic [1:0] req;
    rgb_t       col;
    logic       typed;
    rgb_t       want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       wr_en = 1'b0;
  logic [7:0] wr_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] req_type = REQ_SET;
  logic [7:0] red = 8'd0;
  logic [7:0] green = 8'd0;
  logic [7:0] blue = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  // Predicted LED state
  bit          breath_on;
  int unsigned phase_cnt;
  rgb_t        base_rgb;
  logic [7:0]  bright_reg;

  rgb_t pending_led_q[$];
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   cycle_cnt = 0;
  int   sent_cnt = 0;
  int   effective_cnt = 0;
  int   checked_cnt = 0;
  int   err_cnt = 0;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{1'b0, 8'h00, REQ_SET,    '{8'hFF, 8'hFF, 8'hFF}, 1'b1, '{8'h0F, 8'h0F, 8'h0F}},
    '{1'b0, 8'h00, REQ_SET,    '{8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'h00, REQ_SET,    '{8'h80, 8'h01, 8'hFE}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'h00, REQ_TICK,   '{8'hAA, 8'h55, 8'hFF}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'h00, REQ_UNUSED, '{8'hFF, 8'hFF, 8'hFF}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'h00, REQ_BREATH, '{8'hFF, 8'hFF, 8'hFF}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'h00, REQ_TICK,   '{8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'h00, REQ_BREATH, '{8'hFF, 8'hFF, 8'hFF}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'h00, REQ_TICK,   '{8'h55, 8'hAA, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'h00, REQ_BREATH, '{8'h00, 8'h00, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'h00, REQ_TICK,   '{8'hFF, 8'hFF, 8'hFF}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{1'b1, 8'hFF, REQ_SET,    '{8'h00, 8'h00, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'h00, REQ_SET,    '{8'hFF, 8'h80, 8'h01}, 1'b1, '{8'hFF, 8'h80, 8'h01}},
    '{1'b0, 8'h00, REQ_TICK,   '{8'h12, 8'h34, 8'h56}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'h00, REQ_UNUSED, '{8'h55, 8'hAA, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{1'b1, 8'h00, REQ_SET,    '{8'h00, 8'h00, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'h00, REQ_SET,    '{8'hFF, 8'hFF, 8'hFF}, 1'b1, '{8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'h00, REQ_BREATH, '{8'hFF, 8'h80, 8'h01}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'h00, REQ_TICK,   '{8'hAA, 8'h55, 8'hAA}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'h00, REQ_SET,    '{8'h7F, 8'h7F, 8'h7F}, 1'b1, '{8'h00, 8'h00, 8'h00}},
    '{1'b1, 8'h0F, REQ_SET,    '{8'h00, 8'h00, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00}}
  };

  rgb_breathing_led_generator dut (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_data   (wr_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // c * k / 255 per channel
  function automatic logic [7:0] scale_level(input logic [7:0] c, input logic [7:0] k);
    int unsigned prod;
    prod = c * k;
    return 8'(prod / FULL_SCALE);
  endfunction

  // Triangle over the period, cubic gamma, then scaled to the breathing peak
  function automatic logic [7:0] envelope_amp(input int unsigned ph);
    int unsigned half_len;
    int unsigned lin;
    int unsigned gam;
    half_len = PHASE_COUNT / 2;
    if (ph < half_len) begin
      lin = ph * FULL_SCALE / half_len;
    end else begin
      lin = (PHASE_COUNT - ph) * FULL_SCALE / half_len;
    end
    if (lin > FULL_SCALE) begin
      lin = FULL_SCALE;
    end
    gam = lin * lin * lin / (FULL_SCALE * FULL_SCALE);
    return 8'(gam * BREATH_PEAK / FULL_SCALE);
  endfunction

  // Steps the predicted state; returns 1 when the request had any effect
  function automatic bit predict_led_value(input logic [1:0] req, input rgb_t col,
                                           output rgb_t led, output bit has_led);
    logic [7:0] amp;
    led = '0;
    has_led = 1'b0;
    case (req)
      REQ_SET: begin
        breath_on = 1'b0;
        led.r = scale_level(col.r, bright_reg);
        led.g = scale_level(col.g, bright_reg);
        led.b = scale_level(col.b, bright_reg);
        has_led = 1'b1;
        return 1'b1;
      end
      REQ_BREATH: begin
        if (breath_on && col == base_rgb) begin
          return 1'b0;
        end
        base_rgb = col;
        phase_cnt = 0;
        breath_on = 1'b1;
        return 1'b1;
      end
      REQ_TICK: begin
        if (!breath_on) begin
          return 1'b0;
        end
        phase_cnt = (phase_cnt + 1) % PHASE_COUNT;
        amp = envelope_amp(phase_cnt);
        led.r = scale_level(base_rgb.r, amp);
        led.g = scale_level(base_rgb.g, amp);
        led.b = scale_level(base_rgb.b, amp);
        has_led = 1'b1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Mostly random levels, with the extremes forced now and then
  function automatic rgb_t rand_colour();
    rgb_t col;
    col.r = ($urandom_range(0, 4) == 0) ? {8{1'($urandom_range(0, 1))}} : 8'($urandom);
    col.g = ($urandom_range(0, 4) == 0) ? {8{1'($urandom_range(0, 1))}} : 8'($urandom);
    col.b = ($urandom_range(0, 4) == 0) ? {8{1'($urandom_range(0, 1))}} : 8'($urandom);
    return col;
  endfunction

  // Present one request, hold it until taken, then maybe leave a gap
  task automatic send_item(input logic [1:0] req, input rgb_t col,
                           input bit typed = 1'b0, input rgb_t want = '0);
    rgb_t led;
    bit   has_led;
    in_valid <= 1'b1;
    req_type <= req;
    red      <= col.r;
    green    <= col.g;
    blue     <= col.b;
    do @(posedge clk); while (in_stall);
    sent_cnt++;
    if (predict_led_value(req, col, led, has_led)) begin
      effective_cnt++;
    end
    if (has_led) begin
      pending_led_q.push_back(typed ? want : led);
    end
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_led_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write only once the block has gone quiet
  task automatic write_brightness(input logic [7:0] val);
    drain_results();
    wr_en   <= 1'b1;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    bright_reg = val;
  endtask

  // Breathing runs with random colors dominate; set bursts and noise mixed in
  task automatic run_random(input int target);
    int   start_cnt;
    int   kind;
    int   n;
    rgb_t col;
    start_cnt = sent_cnt;
    while (sent_cnt - start_cnt < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        col = rand_colour();
        send_item(REQ_BREATH, col);
        n = $urandom_range(1, 130);
        for (int i = 0; i < n && sent_cnt - start_cnt < target; i++) begin
          kind = $urandom_range(0, 99);
          if (kind < 4) begin
            send_item(REQ_BREATH, col);
          end else if (kind < 6) begin
            col = rand_colour();
            send_item(REQ_BREATH, col);
          end else begin
            send_item(REQ_TICK, rand_colour());
          end
        end
      end else if (kind < 85) begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n && sent_cnt - start_cnt < target; i++) begin
          send_item(REQ_SET, rand_colour());
        end
      end else begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n && sent_cnt - start_cnt < target; i++) begin
          send_item(2'($urandom_range(0, 3)), rand_colour());
        end
      end
    end
  endtask

  // Result checker and receiver stall
  always @(posedge clk) begin : led_monitor
    rgb_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_led_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("[%0t] unexpected result r=%0d g=%0d b=%0d",
                   $realtime, out_red, out_green, out_blue);
        end
      end else begin
        want = pending_led_q.pop_front();
        checked_cnt++;
        if (out_red !== want.r || out_green !== want.g || out_blue !== want.b) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("[%0t] mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     $realtime, want.r, want.g, want.b, out_red, out_green, out_blue);
          end
        end
      end
    end
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_cnt, pending_led_q.size());
    $display("rgb_breathing_led_generator_tb: FAIL");
    $finish;
  end

  initial begin
    int idle_by_phase [NUM_PHASES];
    int stall_by_phase [NUM_PHASES];
    logic [7:0] bright_by_phase [NUM_PHASES];
    idle_by_phase   = '{0, 45, 0, 15};
    stall_by_phase  = '{0, 0, 45, 15};
    bright_by_phase = '{8'($urandom_range(1, 254)), 8'hFF, 8'h00, 8'($urandom)};

    breath_on  = 1'b0;
    phase_cnt  = 0;
    base_rgb   = '0;
    bright_reg = 8'd15;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg) begin
        write_brightness(directed_rows[i].cfg_val);
      end else begin
        send_item(directed_rows[i].req, directed_rows[i].col,
                  directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases, each with its own brightness and idle pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_brightness(bright_by_phase[p]);
      idle_pct  = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      run_random(ITEMS_PER_PHASE);
    end

    drain_results();

    $display("requests sent: %0d (%0d with effect), results checked: %0d",
             sent_cnt, effective_cnt, checked_cnt);
    $display("covered %0d brightness settings and %0d idle/stall mixes, %0d errors",
             NUM_PHASES + 3, NUM_PHASES, err_cnt);
    if (err_cnt == 0 && pending_led_q.size() == 0) begin
      $display("rgb_breathing_led_generator_tb: PASS");
    end else begin
      $display("rgb_breathing_led_generator_tb: FAIL");
    end
    $finish;
  end

endmodule
